>>> rtl/tfds_pkg.sv
// tfds_pkg: shared types and constants of the top-k footrule distance core
// no dependencies; imported by tfds_cell and topk_footrule_distance_sum_core
`default_nettype none

package tfds_pkg;

  // fixed field widths of the transaction ports
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned ITEM_PORT_W = 16;
  localparam int unsigned IMP_W       = 16;
  localparam int unsigned TOTAL_W     = 40;
  localparam int unsigned LEN_W       = 6;

  // list length after reset
  localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;

  // input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_CAND = 2'd0,
    CMD_REF  = 2'd1,
    CMD_EMIT = 2'd2
  } cmd_e;

  // compare pass sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INJECT,
    ST_DRAIN,
    ST_MUL,
    ST_ACC
  } state_e;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic start;      // clear match state for a new pass
    logic cand_we;    // candidate write at the broadcast index
    logic ref_we;     // reference write at the broadcast index
    logic ref_shift;  // move reference entries one cell toward the head
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/topk_footrule_distance_sum_core.sv
// topk_footrule_distance_sum_core: top level, depends on tfds_pkg and tfds_cell
// items load one per cycle when in_stall_o is low; the transaction that completes a reference list
// starts a compare pass of k reference tokens and one sum token through the MAX_LIST_LENGTH-cell
// chain, then one multiply and one saturating add; the input stalls until the pass returns to idle;
// an emit shows its result next cycle; reset clears fill counts, weight, total, flag and control;
// list entries stay undefined
`default_nettype none

module topk_footrule_distance_sum_core import tfds_pkg::*; #(
  parameter int unsigned MAX_LIST_LENGTH = 32,
  parameter int unsigned ITEM_BITS       = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [LEN_W-1:0]       cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [CMD_W-1:0]       in_cmd_i,
  input  wire logic [ITEM_PORT_W-1:0] in_item_i,
  input  wire logic [IMP_W-1:0]       in_importance_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [TOTAL_W-1:0]          out_total_distance_o,
  output logic                        out_saturated_o
);

  localparam int unsigned IDX_W   = $clog2(MAX_LIST_LENGTH);
  localparam int unsigned K_W     = $clog2(MAX_LIST_LENGTH + 1);
  localparam int unsigned STORE_W = (ITEM_BITS < ITEM_PORT_W) ? ITEM_BITS : ITEM_PORT_W;
  localparam int unsigned DIST_W  = $clog2(2 * MAX_LIST_LENGTH * MAX_LIST_LENGTH + 1);
  localparam int unsigned PROD_W  = DIST_W + IMP_W;
  localparam int unsigned TOK_W   = 3 + IDX_W + STORE_W + DIST_W;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic               found;
    logic [IDX_W-1:0]   idx;
    logic [STORE_W-1:0] value;
    logic [DIST_W-1:0]  dsum;
  } tok_t;

  state_e              state_q, state_d;
  logic [LEN_W-1:0]    len_q;
  logic [K_W-1:0]      k_eff;
  logic [K_W-1:0]      cand_fill_q, cand_fill_d;
  logic [K_W-1:0]      ref_fill_q, ref_fill_d;
  logic [K_W-1:0]      cand_pos, ref_pos;
  logic [IMP_W-1:0]    weight_q, weight_d;
  logic [K_W-1:0]      cnt_q, cnt_d;
  logic [DIST_W-1:0]   miss_q, miss_d;
  logic [DIST_W-1:0]   dist_q, dist_d;
  logic [PROD_W-1:0]   prod_q;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic                sat_q, sat_d;
  logic                out_valid_q, out_valid_d;
  logic [TOTAL_W-1:0]  out_total_q;
  logic                out_sat_q;
  logic [TOTAL_W:0]    sum_wide;
  logic                in_acc;
  logic                ref_done;
  logic [STORE_W-1:0]  item_m;
  cell_ctl_t           ctl;
  logic [IDX_W-1:0]    wr_idx;
  tok_t                inject;
  tok_t                exit_tok;
  logic [TOK_W-1:0]    tok_w [MAX_LIST_LENGTH+1];
  logic [STORE_W-1:0]  ref_w [MAX_LIST_LENGTH+1];

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  // effective list length, clamped to 1..MAX_LIST_LENGTH
  always_comb begin
    if (len_q == '0) begin
      k_eff = K_W'(1);
    end else if (32'(len_q) > MAX_LIST_LENGTH) begin
      k_eff = K_W'(MAX_LIST_LENGTH);
    end else begin
      k_eff = K_W'(len_q);
    end
  end

  // input handshake
  assign in_stall_o = (state_q != ST_IDLE) ||
                      ((in_cmd_i == CMD_EMIT) && out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign item_m     = STORE_W'(in_item_i);

  // fill positions, restarting a list that is full under the current length
  assign cand_pos = (cand_fill_q >= k_eff) ? '0 : cand_fill_q;
  assign ref_pos  = (ref_fill_q >= k_eff) ? '0 : ref_fill_q;
  assign ref_done = in_acc && (in_cmd_i == CMD_REF) && ((ref_pos + K_W'(1)) == k_eff);

  // sequencer, list loading, totals and output register
  always_comb begin
    state_d      = state_q;
    cand_fill_d  = cand_fill_q;
    ref_fill_d   = ref_fill_q;
    weight_d     = weight_q;
    cnt_d        = cnt_q;
    miss_d       = miss_q;
    dist_d       = dist_q;
    total_d      = total_q;
    sat_d        = sat_q;
    out_valid_d  = out_valid_q && out_stall_i;
    ctl          = '0;
    wr_idx       = IDX_W'(cand_pos);
    inject       = '0;
    sum_wide     = {1'b0, total_q} + (TOTAL_W + 1)'(prod_q);

    // reference tokens that left the chain unmatched
    if (exit_tok.valid && !exit_tok.last && !exit_tok.found) begin
      miss_d = miss_q + DIST_W'(k_eff - K_W'(exit_tok.idx));
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_e'(in_cmd_i))
            CMD_CAND: begin
              ctl.cand_we = 1'b1;
              wr_idx      = IDX_W'(cand_pos);
              cand_fill_d = cand_pos + K_W'(1);
            end
            CMD_REF: begin
              ctl.ref_we = 1'b1;
              wr_idx     = IDX_W'(ref_pos);
              if (ref_pos == '0) begin
                weight_d = in_importance_i;
              end
              if (ref_done) begin
                ctl.start  = 1'b1;
                ref_fill_d = '0;
                cnt_d      = '0;
                miss_d     = '0;
                state_d    = ST_INJECT;
              end else begin
                ref_fill_d = ref_pos + K_W'(1);
              end
            end
            CMD_EMIT: begin
              out_valid_d = 1'b1;
              total_d     = '0;
              sat_d       = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_INJECT: begin
        inject.valid = 1'b1;
        inject.idx   = IDX_W'(cnt_q);
        inject.value = ref_w[0];
        if (cnt_q == k_eff) begin
          inject.last = 1'b1;
          state_d     = ST_DRAIN;
        end else begin
          ctl.ref_shift = 1'b1;
          cnt_d         = cnt_q + K_W'(1);
        end
      end
      ST_DRAIN: begin
        if (exit_tok.valid && exit_tok.last) begin
          dist_d  = exit_tok.dsum + miss_q;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (sum_wide >= {1'b0, {TOTAL_W{1'b1}}}) begin
          total_d = '1;
          sat_d   = 1'b1;
        end else begin
          total_d = sum_wide[TOTAL_W-1:0];
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cand_fill_q <= '0;
      ref_fill_q  <= '0;
      weight_q    <= '0;
      cnt_q       <= '0;
      miss_q      <= '0;
      total_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cand_fill_q <= cand_fill_d;
      ref_fill_q  <= ref_fill_d;
      weight_q    <= weight_d;
      cnt_q       <= cnt_d;
      miss_q      <= miss_d;
      total_q     <= total_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers: distance, product, emitted total
  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(dist_q) * PROD_W'(weight_q);
    end
    if (state_q == ST_IDLE && in_acc && in_cmd_i == CMD_EMIT) begin
      out_total_q <= total_q;
      out_sat_q   <= sat_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_total_distance_o = out_total_q;
  assign out_saturated_o      = out_sat_q;

  // chain of cells
  assign tok_w[0]               = inject;
  assign ref_w[MAX_LIST_LENGTH] = '0;
  assign exit_tok               = tok_w[MAX_LIST_LENGTH];

  for (genvar g = 0; g < MAX_LIST_LENGTH; g++) begin : g_cell
    tfds_cell #(
      .IDX     (g),
      .IDX_W   (IDX_W),
      .K_W     (K_W),
      .STORE_W (STORE_W),
      .DIST_W  (DIST_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .k_i        (k_eff),
      .ctl_i      (ctl),
      .wr_idx_i   (wr_idx),
      .wr_item_i  (item_m),
      .ref_next_i (ref_w[g+1]),
      .ref_o      (ref_w[g]),
      .tok_i      (tok_w[g]),
      .tok_o      (tok_w[g+1])
    );
  end

  // a compare pass holds off new transactions
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("transaction accepted during compare pass");

  // the closing token only leaves the chain while the sequencer waits for it
  a_last_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exit_tok.valid && exit_tok.last) |-> (state_q == ST_DRAIN))
    else $error("closing token outside drain");

  // token injection never runs past the list length
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INJECT) |-> (cnt_q <= k_eff))
    else $error("injection count beyond list length");

  // a saturated result carries the full-scale total
  a_sat_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_saturated_o) |-> (out_total_distance_o == {TOTAL_W{1'b1}}))
    else $error("saturated flag without full-scale total");

  // the accumulate step hands back to idle
  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |=> (state_q == ST_IDLE))
    else $error("accumulate step not followed by idle");

endmodule

`default_nettype wire

>>> rtl/tfds_cell.sv
// tfds_cell: one position of the candidate/reference lists plus one token stage
// depends on tfds_pkg (cell_ctl_t)
`default_nettype none

module tfds_cell import tfds_pkg::*; #(
  parameter int unsigned IDX     = 0,
  parameter int unsigned IDX_W   = 5,
  parameter int unsigned K_W     = 6,
  parameter int unsigned STORE_W = 16,
  parameter int unsigned DIST_W  = 12
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic [K_W-1:0]                         k_i,
  input  wire cell_ctl_t                              ctl_i,
  input  wire logic [IDX_W-1:0]                       wr_idx_i,
  input  wire logic [STORE_W-1:0]                     wr_item_i,
  input  wire logic [STORE_W-1:0]                     ref_next_i,
  output logic      [STORE_W-1:0]                     ref_o,
  input  wire logic [3+IDX_W+STORE_W+DIST_W-1:0]      tok_i,
  output logic      [3+IDX_W+STORE_W+DIST_W-1:0]      tok_o
);

  typedef struct packed {
    logic               valid;
    logic               last;   // closing token that collects the candidate sum
    logic               found;
    logic [IDX_W-1:0]   idx;
    logic [STORE_W-1:0] value;
    logic [DIST_W-1:0]  dsum;
  } tok_t;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [K_W-1:0]   MY_K   = K_W'(IDX);

  logic [STORE_W-1:0] cand_q;
  logic [STORE_W-1:0] ref_q;
  logic               matched_q;
  logic [IDX_W-1:0]   pos_q;
  tok_t               tok_in;
  tok_t               tok_d, tok_q;
  logic               active;
  logic               hit;
  logic [IDX_W-1:0]   pos_diff;
  logic [DIST_W-1:0]  contrib;

  assign tok_in = tok_t'(tok_i);

  // list storage, written at its own index; reference entries shift toward the head
  always_ff @(posedge clk_i) begin
    if (ctl_i.cand_we && wr_idx_i == MY_IDX) begin
      cand_q <= wr_item_i;
    end
    if (ctl_i.ref_we && wr_idx_i == MY_IDX) begin
      ref_q <= wr_item_i;
    end else if (ctl_i.ref_shift) begin
      ref_q <= ref_next_i;
    end
  end

  assign ref_o = ref_q;

  // match against passing reference tokens
  assign active = MY_K < k_i;
  assign hit    = active && tok_in.valid && !tok_in.last && (cand_q == tok_in.value);

  // first match wins since tokens arrive in increasing index order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q <= 1'b0;
    end else if (ctl_i.start) begin
      matched_q <= 1'b0;
    end else if (hit) begin
      matched_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit && !matched_q) begin
      pos_q <= tok_in.idx;
    end
  end

  // candidate term of this position
  always_comb begin
    pos_diff = (MY_IDX >= pos_q) ? (MY_IDX - pos_q) : (pos_q - MY_IDX);
    if (!active) begin
      contrib = '0;
    end else if (matched_q) begin
      contrib = DIST_W'(pos_diff);
    end else begin
      contrib = DIST_W'(k_i - MY_K);
    end
  end

  // token stage toward the next cell
  always_comb begin
    tok_d       = tok_in;
    tok_d.found = tok_in.found | hit;
    if (tok_in.valid && tok_in.last) begin
      tok_d.dsum = tok_in.dsum + contrib;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire
